[design/paf_pkg.sv]
// ----------------------------------------------------------------------------
// paf_pkg
// Shared types, constants and match tables of the path access filter.
// ----------------------------------------------------------------------------
package paf_pkg;

  localparam int MAX_SEGMENT_LEN = 16;
  localparam int NAME_COUNT      = 37;
  localparam int PREFIX_COUNT    = 13;
  localparam int MAX_PREFIX_LEN  = 22;

  localparam int NAME_TAB_COUNT   = 37;
  localparam int NAME_TAB_LEN     = 16;
  localparam int PREFIX_TAB_COUNT = 13;
  localparam int PREFIX_TAB_LEN   = 22;
  localparam int PROT_COUNT       = 2;
  localparam int PROT_LEN         = 8;
  localparam int EXT_COUNT        = 5;
  localparam int EXT_LEN          = 4;
  localparam int POS_W            = 5;
  localparam int EXT_POS_W        = 3;
  localparam int QUEUE_DEPTH      = 2;

  typedef enum logic [2:0] {
    RSN_OK        = 3'd0,
    RSN_EMPTY     = 3'd1,
    RSN_SYSTEM    = 3'd2,
    RSN_SENSITIVE = 3'd3,
    RSN_PROTECTED = 3'd4,
    RSN_SCRIPT    = 3'd5
  } reason_t;

  // Classified character handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
    logic [2:0] flags;
    logic       sep;
  } beat_t;

  typedef logic [NAME_TAB_LEN*8-1:0]   name_str_t;
  typedef logic [PREFIX_TAB_LEN*8-1:0] prefix_str_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    return r;
  endfunction

  // Strings are left aligned: character 0 in the top byte
  function automatic name_str_t name_str(input int i);
    name_str_t s;
    s = '0;
    case (i)
      0:  s = {".ssh",             96'h0};
      1:  s = {".env",             96'h0};
      2:  s = {".gnupg",           80'h0};
      3:  s = {".pgp",             96'h0};
      4:  s = {".aws",             96'h0};
      5:  s = {".azure",           80'h0};
      6:  s = {".kube",            88'h0};
      7:  s = {".docker",          72'h0};
      8:  s = {".npmrc",           80'h0};
      9:  s = {".pypirc",          72'h0};
      10: s = {".netrc",           80'h0};
      11: s = {".gitconfig",       48'h0};
      12: s = ".git-credentials";
      13: s = {"id_rsa",           80'h0};
      14: s = {"id_ed", "25519",   48'h0};
      15: s = {"id_", "ecdsa",     64'h0};
      16: s = {"id_dsa",           80'h0};
      17: s = {"authorized", "_keys", 8'h0};
      18: s = {"known", "_hosts",  40'h0};
      19: s = {"password",         64'h0};
      20: s = {"passwords",        56'h0};
      21: s = {"passwd",           80'h0};
      22: s = {"shadow",           80'h0};
      23: s = {"secret",           80'h0};
      24: s = {"secrets",          72'h0};
      25: s = {"credentials",      40'h0};
      26: s = {"token",            88'h0};
      27: s = {"tokens",           80'h0};
      28: s = {"private", "_key",  40'h0};
      29: s = {"private.key",      40'h0};
      30: s = {"master.key",       48'h0};
      31: s = {".env.local",       48'h0};
      32: s = {".env.production",  8'h0};
      33: s = ".env.development";
      34: s = {"wp-config.php",    24'h0};
      35: s = {"web.config",       48'h0};
      36: s = "appsettings.json";
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic int name_len(input int i);
    int n;
    name_str_t s;
    s = name_str(i);
    n = 0;
    for (int k = 0; k < NAME_TAB_LEN; k++)
      if (s[(NAME_TAB_LEN-1-k)*8 +: 8] != 8'h00) n = k + 1;
    return n;
  endfunction

  function automatic logic [7:0] name_char(input int i, input int p);
    logic [7:0] c;
    name_str_t  s;
    s = name_str(i);
    c = 8'h00;
    if (p >= 0 && p < NAME_TAB_LEN) c = s[(NAME_TAB_LEN-1-p)*8 +: 8];
    return c;
  endfunction

  function automatic prefix_str_t prefix_str(input int i);
    prefix_str_t s;
    s = '0;
    case (i)
      0:  s = {"C:\\Windows",             96'h0};
      1:  s = {"C:\\Program Files",       48'h0};
      2:  s = "C:\\Program Files (x86)";
      3:  s = {"C:\\ProgramData",         64'h0};
      4:  s = {"/etc",                    144'h0};
      5:  s = {"/boot",                   136'h0};
      6:  s = {"/sbin",                   136'h0};
      7:  s = {"/usr/sbin",               104'h0};
      8:  s = {"/var/log",                112'h0};
      9:  s = {"/proc",                   136'h0};
      10: s = {"/sys",                    144'h0};
      11: s = {"/dev",                    144'h0};
      12: s = {"/root",                   136'h0};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic int prefix_len(input int i);
    int n;
    prefix_str_t s;
    s = prefix_str(i);
    n = 0;
    for (int k = 0; k < PREFIX_TAB_LEN; k++)
      if (s[(PREFIX_TAB_LEN-1-k)*8 +: 8] != 8'h00) n = k + 1;
    return n;
  endfunction

  function automatic logic [7:0] prot_char(input int i, input int p);
    logic [PROT_LEN*8-1:0] s;
    s = (i == 0) ? {8'h58, 8'h55, 8'h41, 8'h4E, 8'h4A, 8'h49, ".h"}
                 : {8'h6F, 8'h61, 8'h5F, 8'h70, 8'h61, 8'h6C, ".h"};
    return s[(PROT_LEN-1-p)*8 +: 8];
  endfunction

  function automatic logic [7:0] ext_char(input int i, input int p);
    logic [EXT_LEN*8-1:0] s;
    case (i)
      0: s = ".bat";
      1: s = ".cmd";
      2: s = ".ps1";
      3: s = ".vbs";
      default: s = ".wsf";
    endcase
    return s[(EXT_LEN-1-p)*8 +: 8];
  endfunction

endpackage

[design/paf_if.sv]
// ----------------------------------------------------------------------------
// paf_in_if / paf_out_if
// Valid/ready channels of the path access filter.
// ----------------------------------------------------------------------------
interface paf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic       last_byte;
  logic       no_char;
  logic [2:0] access_flags;
  modport source (output valid, path_byte, last_byte, no_char, access_flags, input ready);
  modport sink   (input valid, path_byte, last_byte, no_char, access_flags, output ready);
endinterface

interface paf_out_if;
  logic       valid;
  logic       ready;
  logic       allowed;
  logic [2:0] deny_reason;
  modport source (output valid, allowed, deny_reason, input ready);
  modport sink   (input valid, allowed, deny_reason, output ready);
endinterface

[design/paf_front.sv]
// ----------------------------------------------------------------------------
// paf_front
// Accepts path beats, drops idle beats, classifies separators, and queues them.
// ----------------------------------------------------------------------------
module paf_front (
  input  logic            clk,
  input  logic            rst_n,
  paf_in_if.sink          in_ch,
  output paf_pkg::beat_t  q_data,
  output logic            q_valid,
  input  logic            q_pop
);

  paf_pkg::beat_t mem_r [paf_pkg::QUEUE_DEPTH];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r, count_nxt;
  logic           push;
  paf_pkg::beat_t b;

  assign in_ch.ready = (count_r != 2'(paf_pkg::QUEUE_DEPTH));
  assign push = in_ch.valid && in_ch.ready && (!in_ch.no_char || in_ch.last_byte);

  always_comb begin
    b.ch       = in_ch.path_byte;
    b.has_char = !in_ch.no_char;
    b.last     = in_ch.last_byte;
    b.flags    = in_ch.access_flags;
    b.sep      = (in_ch.path_byte == 8'h2F) || (in_ch.path_byte == 8'h5C);
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= b;
  end

  assign q_valid = (count_r != 2'd0);
  assign q_data  = mem_r[rd_ptr_r];

endmodule

[design/paf_back.sv]
// ----------------------------------------------------------------------------
// paf_back
// Streams characters through the match vectors and registers one verdict.
// ----------------------------------------------------------------------------
module paf_back #(
  parameter int NAME_COUNT   = paf_pkg::NAME_COUNT,
  parameter int PREFIX_COUNT = paf_pkg::PREFIX_COUNT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  paf_pkg::beat_t  q_data,
  input  logic            q_valid,
  output logic            q_pop,
  paf_out_if.source       out_ch
);

  localparam int PW = paf_pkg::POS_W;
  localparam int EW = paf_pkg::EXT_POS_W;

  logic [NAME_COUNT-1:0]         name_alive_r, name_nxt;
  logic [PREFIX_COUNT-1:0]       prefix_alive_r, prefix_nxt;
  logic [paf_pkg::PROT_COUNT-1:0] prot_alive_r, prot_nxt;
  logic [paf_pkg::EXT_COUNT-1:0] ext_alive_r, ext_nxt;
  logic [PW-1:0] seg_pos_r, seg_nxt, path_pos_r, path_nxt;
  logic [EW-1:0] ext_pos_r, ext_pos_nxt;
  logic          sys_hit_r, sys_nxt, sens_hit_r, sens_nxt;
  logic          out_valid_r, allowed_r;
  logic [2:0]    reason_r;
  logic          take;
  logic [7:0]    c;
  logic          seg_sens, end_sys, end_sens;
  paf_pkg::reason_t rsn;

  assign q_pop = q_valid && (!out_valid_r || out_ch.ready || !q_data.last);
  assign take  = q_pop;
  assign c     = paf_pkg::fold(q_data.ch);

  always_comb begin
    name_nxt    = name_alive_r;
    prefix_nxt  = prefix_alive_r;
    prot_nxt    = prot_alive_r;
    ext_nxt     = ext_alive_r;
    seg_nxt     = seg_pos_r;
    path_nxt    = path_pos_r;
    ext_pos_nxt = ext_pos_r;
    sys_nxt     = sys_hit_r;
    sens_nxt    = sens_hit_r;
    seg_sens    = 1'b0;
    for (int i = 0; i < NAME_COUNT; i++)
      if (name_alive_r[i] && seg_pos_r != '0 &&
          int'(seg_pos_r) == paf_pkg::name_len(i % paf_pkg::NAME_TAB_COUNT))
        seg_sens = 1'b1;
    if (q_data.has_char) begin
      for (int i = 0; i < PREFIX_COUNT; i++) begin
        if (prefix_alive_r[i]) begin
          if (int'(path_pos_r) < paf_pkg::prefix_len(i % paf_pkg::PREFIX_TAB_COUNT)) begin
            if (c != paf_pkg::fold(paf_pkg::prefix_str(i % paf_pkg::PREFIX_TAB_COUNT)
                  [(paf_pkg::PREFIX_TAB_LEN-1-int'(path_pos_r))*8 +: 8]))
              prefix_nxt[i] = 1'b0;
          end else begin
            if (int'(path_pos_r) == paf_pkg::prefix_len(i % paf_pkg::PREFIX_TAB_COUNT)
                && q_data.sep)
              sys_nxt = 1'b1;
            prefix_nxt[i] = 1'b0;
          end
        end
      end
      if (path_pos_r != '1) path_nxt = path_pos_r + 1'b1;
      if (q_data.sep) begin
        if (seg_sens) sens_nxt = 1'b1;
        name_nxt    = '1;
        seg_nxt     = '0;
        prot_nxt    = '1;
        ext_nxt     = '0;
        ext_pos_nxt = '0;
      end else begin
        for (int i = 0; i < NAME_COUNT; i++)
          if (!(int'(seg_pos_r) < paf_pkg::name_len(i % paf_pkg::NAME_TAB_COUNT) &&
                c == paf_pkg::fold(paf_pkg::name_char(i % paf_pkg::NAME_TAB_COUNT,
                                                      int'(seg_pos_r)))))
            name_nxt[i] = 1'b0;
        for (int i = 0; i < paf_pkg::PROT_COUNT; i++)
          if (!(int'(seg_pos_r) < paf_pkg::PROT_LEN &&
                c == paf_pkg::fold(paf_pkg::prot_char(i, int'(seg_pos_r) % paf_pkg::PROT_LEN))))
            prot_nxt[i] = 1'b0;
        if (seg_pos_r != '1) seg_nxt = seg_pos_r + 1'b1;
        if (q_data.ch == 8'h2E) begin
          ext_nxt     = '1;
          ext_pos_nxt = EW'(1);
        end else begin
          for (int i = 0; i < paf_pkg::EXT_COUNT; i++)
            if (!(int'(ext_pos_r) < paf_pkg::EXT_LEN &&
                  c == paf_pkg::fold(paf_pkg::ext_char(i, int'(ext_pos_r) % paf_pkg::EXT_LEN))))
              ext_nxt[i] = 1'b0;
          if (ext_pos_r != '1) ext_pos_nxt = ext_pos_r + 1'b1;
        end
      end
    end
    end_sys = sys_nxt;
    for (int i = 0; i < PREFIX_COUNT; i++)
      if (prefix_nxt[i] &&
          int'(path_nxt) == paf_pkg::prefix_len(i % paf_pkg::PREFIX_TAB_COUNT))
        end_sys = 1'b1;
    end_sens = sens_nxt;
    for (int i = 0; i < NAME_COUNT; i++)
      if (name_nxt[i] && seg_nxt != '0 &&
          int'(seg_nxt) == paf_pkg::name_len(i % paf_pkg::NAME_TAB_COUNT))
        end_sens = 1'b1;
    if (path_nxt == '0)                                   rsn = paf_pkg::RSN_EMPTY;
    else if (end_sys)                                     rsn = paf_pkg::RSN_SYSTEM;
    else if (end_sens)                                    rsn = paf_pkg::RSN_SENSITIVE;
    else if (q_data.flags[1:0] != 2'b00 && prot_nxt != '0 &&
             int'(seg_nxt) == paf_pkg::PROT_LEN)          rsn = paf_pkg::RSN_PROTECTED;
    else if (q_data.flags[2] && ext_nxt != '0 &&
             int'(ext_pos_nxt) == paf_pkg::EXT_LEN)       rsn = paf_pkg::RSN_SCRIPT;
    else                                                  rsn = paf_pkg::RSN_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && q_data.last)) begin
      name_alive_r   <= '1;
      prefix_alive_r <= '1;
      prot_alive_r   <= '1;
      ext_alive_r    <= '0;
      seg_pos_r      <= '0;
      path_pos_r     <= '0;
      ext_pos_r      <= '0;
      sys_hit_r      <= 1'b0;
      sens_hit_r     <= 1'b0;
    end else if (take) begin
      name_alive_r   <= name_nxt;
      prefix_alive_r <= prefix_nxt;
      prot_alive_r   <= prot_nxt;
      ext_alive_r    <= ext_nxt;
      seg_pos_r      <= seg_nxt;
      path_pos_r     <= path_nxt;
      ext_pos_r      <= ext_pos_nxt;
      sys_hit_r      <= sys_nxt;
      sens_hit_r     <= sens_nxt;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && q_data.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (take && q_data.last) begin
      allowed_r <= (rsn == paf_pkg::RSN_OK);
      reason_r  <= rsn;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.allowed     = allowed_r;
  assign out_ch.deny_reason = reason_r;

endmodule

[design/path_access_filter.sv]
// ----------------------------------------------------------------------------
// path_access_filter
// Path access filter: one verdict per path, one path byte per cycle while not stalled.
// The last beat is written into the front queue; the back end pops it and registers
// the verdict, which an output stall holds. A waiting verdict holds back only a last
// beat; later beats queue behind it, and input ready drops when the queue is full.
// Reset: synchronous active-low rst_n clears all match state, the queue and the output.
// ----------------------------------------------------------------------------
module path_access_filter #(
  parameter int NAME_COUNT   = paf_pkg::NAME_COUNT,
  parameter int PREFIX_COUNT = paf_pkg::PREFIX_COUNT
) (
  input  logic clk,
  input  logic rst_n,
  paf_in_if.sink    in_ch,
  paf_out_if.source out_ch
);

  paf_pkg::beat_t q_data;
  logic           q_valid, q_pop;

  paf_front u_front (
    .clk, .rst_n, .in_ch, .q_data, .q_valid, .q_pop
  );

  paf_back #(.NAME_COUNT(NAME_COUNT), .PREFIX_COUNT(PREFIX_COUNT)) u_back (
    .clk, .rst_n, .q_data, .q_valid, .q_pop, .out_ch
  );

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_reason_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.allowed == (out_ch.deny_reason == paf_pkg::RSN_OK)))
    else $error("verdict inconsistent");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.deny_reason))
    else $error("verdict dropped");

endmodule
